### design/sdg_pkg.sv
// Package for the sound direction to goal block: widths, status codes,
// register indexes and the structs passed between pipeline sections.
// No dependencies; every other file imports this package.
`timescale 1ns / 1ps
`default_nettype none

package sdg_pkg;

   // Fixed point format of direction and energy
   localparam int FRAC_BITS = 14;
   // Extra fraction bits of the norm
   localparam int EXT_BITS  = 13;

   localparam int IN_W     = 16;
   localparam int MAG_W    = 16;
   localparam int SQ_W     = 2 * MAG_W;
   localparam int MN_W     = 15;
   localparam int MN2_W    = 2 * MN_W;
   localparam int EC_W     = FRAC_BITS + 1;
   localparam int DIST_W   = IN_W + FRAC_BITS;
   localparam int RAD_W    = SQ_W + 2 * EXT_BITS;
   localparam int ROOT_W   = RAD_W / 2;
   localparam int PROD_W   = MAG_W + DIST_W;
   localparam int DVD_W    = PROD_W + EXT_BITS;
   localparam int DVS_W    = ROOT_W + FRAC_BITS;
   localparam int QUO_W    = 17;
   localparam int CMP_W    = DVS_W + QUO_W;
   localparam int GOAL_W   = 17;
   localparam int GMAG_W   = 16;
   localparam int CSR_W    = 16;
   localparam int CSR_IDX_W = 2;

   localparam logic [EC_W-1:0]   ONE      = EC_W'(1) << FRAC_BITS;
   localparam logic [GMAG_W-1:0] GOAL_MAX = '1;

   // Register indexes
   localparam logic [CSR_IDX_W-1:0] CSR_QUIET_THR  = 2'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_MIN_NORM   = 2'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_NEAR_MM    = 2'd2;
   localparam logic [CSR_IDX_W-1:0] CSR_FAR_MM     = 2'd3;

   // Register reset values
   localparam logic [IN_W-1:0] QUIET_THR_RST  = 16'd1638;
   localparam logic [MN_W-1:0] MIN_NORM_RST   = 15'd164;
   localparam logic [IN_W-1:0] NEAR_MM_RST    = 16'd500;
   localparam logic [IN_W-1:0] FAR_MM_RST     = 16'd3000;

   typedef enum logic [1:0] {
      ST_GOAL     = 2'd0,
      ST_QUIET    = 2'd1,
      ST_VERTICAL = 2'd2
   } sdg_status_type;

   typedef struct packed {
      logic [IN_W-1:0] quiet_thr;
      logic [MN_W-1:0] min_norm;
      logic [IN_W-1:0] near_mm;
      logic [IN_W-1:0] far_mm;
   } sdg_cfg_type;

   // Carried alongside the division
   typedef struct packed {
      logic           neg_x;
      logic           neg_y;
      sdg_status_type status;
   } sdg_dvside_type;

   // Carried alongside the square root
   typedef struct packed {
      logic [PROD_W-1:0] prod_x;
      logic [PROD_W-1:0] prod_y;
      sdg_dvside_type    dv;
   } sdg_sqside_type;

endpackage

`default_nettype wire

### design/sdg_req_if.sv
// Request channel interface: direction and energy of one transaction.
// Depends on sdg_pkg.
`timescale 1ns / 1ps
`default_nettype none

interface sdg_req_if;
   import sdg_pkg::*;

   logic                   valid;
   logic                   ready;
   logic signed [IN_W-1:0] dir_x;
   logic signed [IN_W-1:0] dir_y;
   logic [IN_W-1:0]        energy;

   modport source (output valid, dir_x, dir_y, energy, input ready);
   modport sink   (input valid, dir_x, dir_y, energy, output ready);
endinterface

`default_nettype wire

### design/sdg_rsp_if.sv
// Response channel interface: goal position and status of one transaction.
// Depends on sdg_pkg.
`timescale 1ns / 1ps
`default_nettype none

interface sdg_rsp_if;
   import sdg_pkg::*;

   logic                     valid;
   logic                     ready;
   logic signed [GOAL_W-1:0] goal_x_mm;
   logic signed [GOAL_W-1:0] goal_y_mm;
   logic [1:0]               status;

   modport source (output valid, goal_x_mm, goal_y_mm, status, input ready);
   modport sink   (input valid, goal_x_mm, goal_y_mm, status, output ready);
endinterface

`default_nettype wire

### design/sdg_front.sv
// Front section: magnitudes, squares, distance interpolation, rejection
// status and the direction-times-distance products. Four stages.
// Depends on sdg_pkg.
`timescale 1ns / 1ps
`default_nettype none

module sdg_front (
   input  wire logic                           clock,
   input  wire logic                           reset,
   input  wire logic                           adv,
   input  sdg_pkg::sdg_cfg_type                cfg,
   input  wire logic                           in_valid,
   input  wire logic signed [sdg_pkg::IN_W-1:0] dir_x,
   input  wire logic signed [sdg_pkg::IN_W-1:0] dir_y,
   input  wire logic [sdg_pkg::IN_W-1:0]        energy,
   output logic                                out_valid,
   output logic [sdg_pkg::SQ_W-1:0]             out_sq,
   output sdg_pkg::sdg_sqside_type              out_side
);
   import sdg_pkg::*;

   logic [3:0] vld_ff;

   // Stage 1: magnitudes, clamp, quiet test
   logic [MAG_W-1:0] mx_ff, my_ff, mx_in, my_in;
   logic             nx_ff, ny_ff;
   logic [EC_W-1:0]  ec_ff, ec_in;
   logic             quiet_ff;

   assign mx_in = dir_x[IN_W-1] ? MAG_W'(-dir_x) : MAG_W'(dir_x);
   assign my_in = dir_y[IN_W-1] ? MAG_W'(-dir_y) : MAG_W'(dir_y);
   assign ec_in = (32'(energy) > 32'(ONE)) ? ONE : EC_W'(energy);

   // Stage 2: products
   logic [MAG_W-1:0]  mx2_ff, my2_ff;
   logic              nx2_ff, ny2_ff, quiet2_ff;
   logic [SQ_W-1:0]   sqx_ff, sqy_ff;
   logic [MN2_W-1:0]  mn2_ff;
   logic [DIST_W-1:0] pfar_ff, pnear_ff;

   // Stage 3: sums and status
   logic [MAG_W-1:0]  mx3_ff, my3_ff;
   logic              nx3_ff, ny3_ff;
   logic [SQ_W-1:0]   s_ff, s_in;
   logic [DIST_W-1:0] dist_ff, dist_in;
   sdg_status_type    st3_ff, st3_in;

   assign s_in    = sqx_ff + sqy_ff;
   assign dist_in = pfar_ff + pnear_ff;

   always_comb begin
      priority if (quiet2_ff)
         st3_in = ST_QUIET;
      else if (s_in == '0 || s_in < SQ_W'(mn2_ff))
         st3_in = ST_VERTICAL;
      else
         st3_in = ST_GOAL;
   end

   // Stage 4: direction times distance
   logic [SQ_W-1:0] s4_ff;
   sdg_sqside_type  side4_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff <= '0;
      end else if (adv) begin
         vld_ff <= {vld_ff[2:0], in_valid};
      end
      if (adv) begin
         mx_ff    <= mx_in;
         my_ff    <= my_in;
         nx_ff    <= dir_x[IN_W-1];
         ny_ff    <= dir_y[IN_W-1];
         ec_ff    <= ec_in;
         quiet_ff <= energy < cfg.quiet_thr;

         mx2_ff    <= mx_ff;
         my2_ff    <= my_ff;
         nx2_ff    <= nx_ff;
         ny2_ff    <= ny_ff;
         quiet2_ff <= quiet_ff;
         sqx_ff    <= SQ_W'(mx_ff) * SQ_W'(mx_ff);
         sqy_ff    <= SQ_W'(my_ff) * SQ_W'(my_ff);
         mn2_ff    <= MN2_W'(cfg.min_norm) * MN2_W'(cfg.min_norm);
         pfar_ff   <= DIST_W'(cfg.far_mm) * DIST_W'(ONE - ec_ff);
         pnear_ff  <= DIST_W'(cfg.near_mm) * DIST_W'(ec_ff);

         mx3_ff  <= mx2_ff;
         my3_ff  <= my2_ff;
         nx3_ff  <= nx2_ff;
         ny3_ff  <= ny2_ff;
         s_ff    <= s_in;
         dist_ff <= dist_in;
         st3_ff  <= st3_in;

         s4_ff              <= s_ff;
         side4_ff.prod_x    <= PROD_W'(mx3_ff) * PROD_W'(dist_ff);
         side4_ff.prod_y    <= PROD_W'(my3_ff) * PROD_W'(dist_ff);
         side4_ff.dv.neg_x  <= nx3_ff;
         side4_ff.dv.neg_y  <= ny3_ff;
         side4_ff.dv.status <= st3_ff;
      end
   end

   assign out_valid = vld_ff[3];
   assign out_sq    = s4_ff;
   assign out_side  = side4_ff;

endmodule

`default_nettype wire

### design/sdg_sqrt.sv
// Pipelined integer square root of the squared norm, one result bit per
// stage, carrying the products and status alongside. Depends on sdg_pkg.
`timescale 1ns / 1ps
`default_nettype none

module sdg_sqrt (
   input  wire logic                      clock,
   input  wire logic                      reset,
   input  wire logic                      adv,
   input  wire logic                      in_valid,
   input  wire logic [sdg_pkg::SQ_W-1:0]  radicand,
   input  sdg_pkg::sdg_sqside_type        in_side,
   output logic                           out_valid,
   output logic [sdg_pkg::ROOT_W-1:0]     root,
   output sdg_pkg::sdg_sqside_type        out_side
);
   import sdg_pkg::*;

   logic [ROOT_W-1:0] vld_ff;
   logic [RAD_W-1:0]  rem_ff  [ROOT_W];
   logic [ROOT_W-1:0] root_ff [ROOT_W];
   sdg_sqside_type    side_ff [ROOT_W];

   for (genvar j = 0; j < ROOT_W; j++) begin : g_stage
      localparam int K = ROOT_W - 1 - j;
      logic [RAD_W-1:0]  rem_src;
      logic [ROOT_W-1:0] root_src;
      logic              vld_src;
      sdg_sqside_type    side_src;
      logic [RAD_W:0]    trial;
      logic              take;

      if (j == 0) begin : g_first
         assign rem_src  = {radicand, {(2 * EXT_BITS){1'b0}}};
         assign root_src = '0;
         assign vld_src  = in_valid;
         assign side_src = in_side;
      end else begin : g_next
         assign rem_src  = rem_ff[j-1];
         assign root_src = root_ff[j-1];
         assign vld_src  = vld_ff[j-1];
         assign side_src = side_ff[j-1];
      end

      // Try result bit K: (r + 2^K)^2 - r^2
      assign trial = ((RAD_W + 1)'(root_src) << (K + 1)) | ((RAD_W + 1)'(1) << (2 * K));
      assign take  = {1'b0, rem_src} >= trial;

      always_ff @(posedge clock) begin
         if (reset) begin
            vld_ff[j] <= 1'b0;
         end else if (adv) begin
            vld_ff[j] <= vld_src;
         end
         if (adv) begin
            rem_ff[j]  <= take ? rem_src - trial[RAD_W-1:0] : rem_src;
            root_ff[j] <= take ? (root_src | (ROOT_W'(1) << K)) : root_src;
            side_ff[j] <= side_src;
         end
      end
   end

   assign out_valid = vld_ff[ROOT_W-1];
   assign root      = root_ff[ROOT_W-1];
   assign out_side  = side_ff[ROOT_W-1];

endmodule

`default_nettype wire

### design/sdg_div.sv
// Two-lane pipelined restoring divider: product times 2^EXT_BITS over
// root times 2^FRAC_BITS, overflow check then one quotient bit per stage.
// Depends on sdg_pkg.
`timescale 1ns / 1ps
`default_nettype none

module sdg_div (
   input  wire logic                      clock,
   input  wire logic                      reset,
   input  wire logic                      adv,
   input  wire logic                      in_valid,
   input  wire logic [sdg_pkg::PROD_W-1:0] prod_x,
   input  wire logic [sdg_pkg::PROD_W-1:0] prod_y,
   input  wire logic [sdg_pkg::ROOT_W-1:0] root,
   input  sdg_pkg::sdg_dvside_type        in_side,
   output logic                           out_valid,
   output logic [sdg_pkg::QUO_W-1:0]      quo_x,
   output logic [sdg_pkg::QUO_W-1:0]      quo_y,
   output logic                           ovf_x,
   output logic                           ovf_y,
   output sdg_pkg::sdg_dvside_type        out_side
);
   import sdg_pkg::*;

   localparam int NS = QUO_W + 1;

   logic [NS-1:0]    vld_ff;
   logic [DVS_W-1:0] dvs_ff  [NS];
   logic [DVD_W-1:0] rem_ff  [NS][2];
   logic [QUO_W-1:0] quo_ff  [NS][2];
   logic             ovf_ff  [NS][2];
   sdg_dvside_type   side_ff [NS];

   logic [DVD_W-1:0] dvd_in [2];
   logic [DVS_W-1:0] dvs_in;

   assign dvd_in[0] = {prod_x, {EXT_BITS{1'b0}}};
   assign dvd_in[1] = {prod_y, {EXT_BITS{1'b0}}};
   assign dvs_in    = {root, {FRAC_BITS{1'b0}}};

   // Stage 0: flag quotients that cannot fit
   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff[0] <= 1'b0;
      end else if (adv) begin
         vld_ff[0] <= in_valid;
      end
      if (adv) begin
         dvs_ff[0]  <= dvs_in;
         side_ff[0] <= in_side;
         for (int l = 0; l < 2; l++) begin
            rem_ff[0][l] <= dvd_in[l];
            quo_ff[0][l] <= '0;
            ovf_ff[0][l] <= CMP_W'(dvd_in[l]) >= (CMP_W'(dvs_in) << QUO_W);
         end
      end
   end

   // Quotient stages, most significant bit first
   for (genvar i = 1; i < NS; i++) begin : g_stage
      localparam int B = QUO_W - i;
      logic [CMP_W-1:0] sh;
      logic             take [2];

      assign sh      = CMP_W'(dvs_ff[i-1]) << B;
      assign take[0] = CMP_W'(rem_ff[i-1][0]) >= sh;
      assign take[1] = CMP_W'(rem_ff[i-1][1]) >= sh;

      always_ff @(posedge clock) begin
         if (reset) begin
            vld_ff[i] <= 1'b0;
         end else if (adv) begin
            vld_ff[i] <= vld_ff[i-1];
         end
         if (adv) begin
            dvs_ff[i]  <= dvs_ff[i-1];
            side_ff[i] <= side_ff[i-1];
            for (int l = 0; l < 2; l++) begin
               rem_ff[i][l] <= take[l] ? rem_ff[i-1][l] - sh[DVD_W-1:0] : rem_ff[i-1][l];
               quo_ff[i][l] <= take[l] ? (quo_ff[i-1][l] | (QUO_W'(1) << B))
                                       : quo_ff[i-1][l];
               ovf_ff[i][l] <= ovf_ff[i-1][l];
            end
         end
      end
   end

   assign out_valid = vld_ff[NS-1];
   assign quo_x     = quo_ff[NS-1][0];
   assign quo_y     = quo_ff[NS-1][1];
   assign ovf_x     = ovf_ff[NS-1][0];
   assign ovf_y     = ovf_ff[NS-1][1];
   assign out_side  = side_ff[NS-1];

endmodule

`default_nettype wire

### design/sound_direction_to_goal.sv
// Sound direction to goal: a request passes 4 front stages, 29 square root
// stages, 18 divider stages and 1 output register on its way to the response.
// Throughput one transaction per cycle; the whole pipeline holds while the
// output register is full and not taken. Synchronous active-high reset
// empties the pipeline and loads the register defaults.
// Depends on sdg_pkg, sdg_req_if, sdg_rsp_if, sdg_front, sdg_sqrt, sdg_div.
`timescale 1ns / 1ps
`default_nettype none

module sound_direction_to_goal (
   input  wire logic                          clock,
   input  wire logic                          reset,
   sdg_req_if.sink                            req,
   sdg_rsp_if.source                          rsp,
   input  wire logic                          csr_we,
   input  wire logic [sdg_pkg::CSR_IDX_W-1:0] csr_index,
   input  wire logic [sdg_pkg::CSR_W-1:0]     csr_wdata
);
   import sdg_pkg::*;

   sdg_cfg_type cfg_ff;
   logic        adv;

   // Configuration registers
   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.quiet_thr  <= QUIET_THR_RST;
         cfg_ff.min_norm   <= MIN_NORM_RST;
         cfg_ff.near_mm    <= NEAR_MM_RST;
         cfg_ff.far_mm     <= FAR_MM_RST;
      end else if (csr_we) begin
         unique case (csr_index)
            CSR_QUIET_THR:  cfg_ff.quiet_thr  <= csr_wdata[IN_W-1:0];
            CSR_MIN_NORM:   cfg_ff.min_norm   <= csr_wdata[MN_W-1:0];
            CSR_NEAR_MM:    cfg_ff.near_mm    <= csr_wdata[IN_W-1:0];
            CSR_FAR_MM:     cfg_ff.far_mm     <= csr_wdata[IN_W-1:0];
         endcase
      end
   end

   // Pipeline sections
   logic              f_vld, s_vld, d_vld;
   logic [SQ_W-1:0]   f_sq;
   sdg_sqside_type    f_side, s_side;
   logic [ROOT_W-1:0] s_root;
   logic [QUO_W-1:0]  q_x, q_y;
   logic              o_x, o_y;
   sdg_dvside_type    d_side;

   sdg_front u_front (
      .clock     (clock),
      .reset     (reset),
      .adv       (adv),
      .cfg       (cfg_ff),
      .in_valid  (req.valid),
      .dir_x     (req.dir_x),
      .dir_y     (req.dir_y),
      .energy    (req.energy),
      .out_valid (f_vld),
      .out_sq    (f_sq),
      .out_side  (f_side)
   );

   sdg_sqrt u_sqrt (
      .clock     (clock),
      .reset     (reset),
      .adv       (adv),
      .in_valid  (f_vld),
      .radicand  (f_sq),
      .in_side   (f_side),
      .out_valid (s_vld),
      .root      (s_root),
      .out_side  (s_side)
   );

   sdg_div u_div (
      .clock     (clock),
      .reset     (reset),
      .adv       (adv),
      .in_valid  (s_vld),
      .prod_x    (s_side.prod_x),
      .prod_y    (s_side.prod_y),
      .root      (s_root),
      .in_side   (s_side.dv),
      .out_valid (d_vld),
      .quo_x     (q_x),
      .quo_y     (q_y),
      .ovf_x     (o_x),
      .ovf_y     (o_y),
      .out_side  (d_side)
   );

   // Saturate, apply sign, drop goals of rejected transactions
   logic [GMAG_W-1:0] mag_x, mag_y;
   logic [GOAL_W-1:0] goal_x_in, goal_y_in;

   assign mag_x = (o_x || q_x[QUO_W-1]) ? GOAL_MAX : q_x[GMAG_W-1:0];
   assign mag_y = (o_y || q_y[QUO_W-1]) ? GOAL_MAX : q_y[GMAG_W-1:0];

   always_comb begin
      goal_x_in = '0;
      goal_y_in = '0;
      if (d_side.status == ST_GOAL) begin
         goal_x_in = d_side.neg_x ? GOAL_W'(-{1'b0, mag_x}) : GOAL_W'({1'b0, mag_x});
         goal_y_in = d_side.neg_y ? GOAL_W'(-{1'b0, mag_y}) : GOAL_W'({1'b0, mag_y});
      end
   end

   // Output register
   logic              rsp_valid_ff;
   logic [GOAL_W-1:0] goal_x_ff, goal_y_ff;
   sdg_status_type    status_ff;

   assign adv = !rsp_valid_ff || rsp.ready;

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (adv) begin
         rsp_valid_ff <= d_vld;
      end
      if (adv) begin
         goal_x_ff <= goal_x_in;
         goal_y_ff <= goal_y_in;
         status_ff <= d_side.status;
      end
   end

   assign req.ready     = adv;
   assign rsp.valid     = rsp_valid_ff;
   assign rsp.goal_x_mm = goal_x_ff;
   assign rsp.goal_y_mm = goal_y_ff;
   assign rsp.status    = status_ff;

   // Rejected transactions carry zero goals
   a_reject_zero: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && status_ff != ST_GOAL) |-> (goal_x_ff == '0 && goal_y_ff == '0))
      else $error("rejected transaction with non-zero goal");

   // Reset empties the output register
   a_reset_empty: assert property (@(posedge clock) $past(reset) |-> !rsp_valid_ff)
      else $error("response valid straight after reset");

   // A held pipeline keeps its valid bits
   a_stall_hold: assert property (@(posedge clock) disable iff (reset)
      !adv |=> ($stable(d_vld) && $stable(s_vld) && $stable(f_vld)))
      else $error("pipeline moved while held");

endmodule

`default_nettype wire

### test/tb_sound_direction_to_goal.sv
// Testbench for sound_direction_to_goal: directed table, zero thresholds, then random
// phases; each response checked against its typed result or a predictor of the goal arithmetic.
// Depends on sdg_pkg, sdg_req_if, sdg_rsp_if and the block itself.
`timescale 1ns / 1ps

module tb_sound_direction_to_goal;
   import sdg_pkg::*;

   localparam int LATENCY   = 52;
   localparam int IDLE_LIM  = 5000;
   localparam int LONG_HOLD = 400;

   typedef struct {
      logic signed [GOAL_W-1:0] gx;
      logic signed [GOAL_W-1:0] gy;
      sdg_status_type           st;
   } goal_type;

   typedef struct {
      logic signed [IN_W-1:0] dx;
      logic signed [IN_W-1:0] dy;
      logic [IN_W-1:0]        en;
      bit                     typed;
      goal_type               res;
   } row_type;

   logic clock = 1'b0;
   logic reset = 1'b1;
   logic csr_we = 1'b0;
   logic [CSR_IDX_W-1:0] csr_index = '0;
   logic [CSR_W-1:0]     csr_wdata = '0;

   sdg_req_if req ();
   sdg_rsp_if rsp ();

   sound_direction_to_goal uut (
      .clock(clock), .reset(reset), .req(req.sink), .rsp(rsp.source),
      .csr_we(csr_we), .csr_index(csr_index), .csr_wdata(csr_wdata)
   );

   // local copy of the registers
   logic [IN_W-1:0] thr_energy;
   logic [MN_W-1:0] thr_norm;
   logic [IN_W-1:0] near_mm;
   logic [IN_W-1:0] far_mm;

   goal_type pending_goals[$];
   row_type  dir_table[$];
   int    mismatches = 0;
   int    idle_cycles = 0;
   bit    long_hold_req = 0;
   bit    accepted_now;
   int    burst_left = 0;

   always #5 clock = ~clock;

   initial begin
      req.valid = 1'b0;
      req.dir_x = '0;
      req.dir_y = '0;
      req.energy = '0;
      rsp.ready = 1'b0;
   end

   function automatic logic [63:0] isqrt(logic [63:0] v);
      logic [63:0] r, b;
      r = '0;
      b = 64'd1 << 62;
      while (b > v) b = b >> 2;
      while (b != 0) begin
         if (v >= r + b) begin
            v = v - (r + b);
            r = (r >> 1) + b;
         end else begin
            r = r >> 1;
         end
         b = b >> 2;
      end
      return r;
   endfunction

   function automatic logic signed [GOAL_W-1:0] scale_component(
         logic signed [IN_W-1:0] c, logic [63:0] span, logic [63:0] den);
      logic [63:0] m, q;
      m = (c < 0) ? 64'(-32'(c)) : 64'(c);
      q = ((m * span) << EXT_BITS) / den;
      if (q > 64'(GOAL_MAX)) q = 64'(GOAL_MAX);
      return (c < 0) ? -GOAL_W'(q) : GOAL_W'(q);
   endfunction

   // compute the goal of one direction and energy under the current registers
   function automatic goal_type predict_goal(logic signed [IN_W-1:0] dx,
         logic signed [IN_W-1:0] dy, logic [IN_W-1:0] en);
      goal_type g;
      logic [63:0] s, ec, span, n;
      g.gx = '0;
      g.gy = '0;
      if (en < thr_energy) begin
         g.st = ST_QUIET;
         return g;
      end
      s = 64'(32'(dx) * 32'(dx)) + 64'(32'(dy) * 32'(dy));
      if (s == 0 || s < 64'(thr_norm) * 64'(thr_norm)) begin
         g.st = ST_VERTICAL;
         return g;
      end
      ec = (en > ONE) ? 64'(ONE) : 64'(en);
      span = 64'(far_mm) * (64'(ONE) - ec) + 64'(near_mm) * ec;
      n = isqrt(s << (2 * EXT_BITS));
      g.gx = scale_component(dx, span, 64'(ONE) * n);
      g.gy = scale_component(dy, span, 64'(ONE) * n);
      g.st = ST_GOAL;
      return g;
   endfunction

   task automatic report_mismatch(string what, int got, int want);
      $display("mismatch %s: got %0d, want %0d at %0t", what, got, want, $realtime);
      mismatches++;
   endtask

   // write all four registers back to back, block idle
   task automatic load_registers(logic [IN_W-1:0] me, logic [MN_W-1:0] mn,
         logic [IN_W-1:0] nr, logic [IN_W-1:0] fr);
      @(posedge clock);
      csr_we <= 1'b1; csr_index <= CSR_QUIET_THR; csr_wdata <= me;
      @(posedge clock);
      csr_index <= CSR_MIN_NORM; csr_wdata <= CSR_W'(mn);
      @(posedge clock);
      csr_index <= CSR_NEAR_MM; csr_wdata <= nr;
      @(posedge clock);
      csr_index <= CSR_FAR_MM; csr_wdata <= fr;
      @(posedge clock);
      csr_we <= 1'b0;
      thr_energy = me; thr_norm = mn; near_mm = nr; far_mm = fr;
   endtask

   // offer one transaction, return after the accepting edge and any random gap that follows
   task automatic send_request(row_type r);
      int gap;
      req.valid <= 1'b1;
      req.dir_x <= r.dx;
      req.dir_y <= r.dy;
      req.energy <= r.en;
      do @(negedge clock); while (!req.ready);
      @(posedge clock);
      pending_goals.push_back(r.typed ? r.res : predict_goal(r.dx, r.dy, r.en));
      if (burst_left > 0) begin
         burst_left--;
      end else begin
         burst_left = $urandom_range(0, 40);
         gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 12);
         if (gap > 0) begin
            req.valid <= 1'b0;
            repeat (gap) @(posedge clock);
         end
      end
   endtask

   // drop valid at once, then wait for every response
   task automatic drain_pipeline();
      req.valid <= 1'b0;
      @(posedge clock);
      while (pending_goals.size() != 0) @(posedge clock);
      repeat (LATENCY + 8) @(posedge clock);
   endtask

   function automatic row_type random_request();
      row_type r;
      int k;
      r.typed = 0;
      k = $urandom_range(0, 9);
      if (k < 2) begin
         r.dx = IN_W'($urandom); r.dy = IN_W'($urandom); r.en = IN_W'($urandom);
      end else begin
         // mostly near-unit directions with a plausible energy
         r.dx = $signed(16'($urandom_range(0, 32767))) - 16'sd16384;
         r.dy = $signed(16'($urandom_range(0, 32767))) - 16'sd16384;
         if (k == 2) begin
            r.dx = r.dx >>> $urandom_range(4, 12);
            r.dy = r.dy >>> $urandom_range(4, 12);
         end
         r.en = (k == 3) ? 16'($urandom_range(0, 3000)) : 16'($urandom_range(0, 20000));
      end
      return r;
   endfunction

   function automatic row_type typed_row(int dx, int dy, int en, int gx, int gy,
         sdg_status_type st);
      row_type r;
      r.dx = IN_W'(dx); r.dy = IN_W'(dy); r.en = IN_W'(en); r.typed = 1;
      r.res.gx = GOAL_W'(gx); r.res.gy = GOAL_W'(gy); r.res.st = st;
      return r;
   endfunction

   function automatic row_type checked_row(int dx, int dy, int en);
      row_type r;
      r.dx = IN_W'(dx); r.dy = IN_W'(dy); r.en = IN_W'(en); r.typed = 0;
      return r;
   endfunction

   // receiver: stall pattern, with one long hold-off on request
   always @(posedge clock) begin : rsp_stall
      static int cyc = 0;
      static int hold = 0;
      cyc++;
      if (long_hold_req && hold == 0) begin
         hold = LONG_HOLD;
         long_hold_req = 0;
      end
      if (hold > 0) begin
         hold--;
         rsp.ready <= 1'b0;
      end else begin
         case ((cyc / 300) % 3)
            0: rsp.ready <= 1'b1;
            1: rsp.ready <= ((cyc % 13) < 8);
            default: rsp.ready <= ($urandom_range(0, 3) != 0);
         endcase
      end
   end

   // check each response transaction against the oldest expectation
   always @(negedge clock) begin : rsp_check
      goal_type want;
      accepted_now = (req.valid && req.ready) || (rsp.valid && rsp.ready);
      if (rsp.valid && rsp.ready && !reset) begin
         if (pending_goals.size() == 0) begin
            report_mismatch("unexpected response", 1, 0);
         end else begin
            want = pending_goals.pop_front();
            if (rsp.status !== want.st)
               report_mismatch("status", int'(rsp.status), int'(want.st));
            if (rsp.goal_x_mm !== want.gx)
               report_mismatch("goal_x", int'(rsp.goal_x_mm), int'(want.gx));
            if (rsp.goal_y_mm !== want.gy)
               report_mismatch("goal_y", int'(rsp.goal_y_mm), int'(want.gy));
         end
      end
   end

   // watchdog on cycles without any transaction
   always @(posedge clock) begin
      idle_cycles = accepted_now ? 0 : idle_cycles + 1;
      if (idle_cycles >= IDLE_LIM) begin
         $display("tb_sound_direction_to_goal NOT OK");
         $finish;
      end
   end

   initial begin : stimulus
      int ph;
      repeat (8) @(posedge clock);
      reset <= 1'b0;
      thr_energy = QUIET_THR_RST; thr_norm = MIN_NORM_RST;
      near_mm = NEAR_MM_RST; far_mm = FAR_MM_RST;

      // directed rows under reset registers
      dir_table.push_back(typed_row(16384, 0, 16384, 500, 0, ST_GOAL));
      dir_table.push_back(typed_row(-16384, 0, 65535, -500, 0, ST_GOAL));
      dir_table.push_back(typed_row(0, 16384, 16384, 0, 500, ST_GOAL));
      dir_table.push_back(typed_row(0, -16384, 16384, 0, -500, ST_GOAL));
      dir_table.push_back(typed_row(16384, 16384, 0, 0, 0, ST_QUIET));
      dir_table.push_back(typed_row(-32768, 32767, 1637, 0, 0, ST_QUIET));
      dir_table.push_back(typed_row(0, 0, 16384, 0, 0, ST_VERTICAL));
      dir_table.push_back(typed_row(163, 0, 65535, 0, 0, ST_VERTICAL));
      dir_table.push_back(checked_row(164, 0, 1638));
      dir_table.push_back(checked_row(-32768, -32768, 65535));
      dir_table.push_back(checked_row(32767, 32767, 8192));
      dir_table.push_back(checked_row(-32768, 1, 16385));
      dir_table.push_back(checked_row(1, -1, 40000));
      dir_table.push_back(checked_row(11585, -11585, 12000));
      foreach (dir_table[i]) send_request(dir_table[i]);
      drain_pipeline();

      // zero thresholds: zero direction still vertical, tiny norms pass
      load_registers(16'd0, 15'd0, 16'd0, 16'd0);
      send_request(typed_row(0, 0, 0, 0, 0, ST_VERTICAL));
      send_request(checked_row(1, 0, 0));
      send_request(checked_row(-1, 0, 65535));
      drain_pipeline();

      // random phases over several register settings, extremes included
      for (ph = 0; ph < 6; ph++) begin
         case (ph)
            0: load_registers(QUIET_THR_RST, MIN_NORM_RST, NEAR_MM_RST, FAR_MM_RST);
            1: load_registers(16'd0, 15'd0, 16'd65535, 16'd65535);
            2: load_registers(16'd0, 15'd0, 16'd65535, 16'd0);
            3: load_registers(16'd65535, 15'd16384, 16'd0, 16'd65535);
            4: load_registers(16'd3000, 15'd16384, 16'd1234, 16'd40000);
            default: load_registers(IN_W'($urandom), MN_W'($urandom_range(0, 16384)),
                                    IN_W'($urandom), IN_W'($urandom));
         endcase
         // in phase 1, fill the pipeline against a stalled receiver
         if (ph == 1) long_hold_req = 1;
         repeat (325) send_request(random_request());
         drain_pipeline();
      end

      if (mismatches == 0) begin
         $display("tb_sound_direction_to_goal OK");
      end else begin
         $display("tb_sound_direction_to_goal NOT OK");
      end
      $finish;
   end

endmodule

### sim.f
design/sdg_pkg.sv
design/sdg_req_if.sv
design/sdg_rsp_if.sv
design/sdg_front.sv
design/sdg_sqrt.sv
design/sdg_div.sv
design/sound_direction_to_goal.sv
test/tb_sound_direction_to_goal.sv
